FILE: rtl/core/fcwkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwkt_pkg
// Types and constants shared by the keyed-take FIFO cache core and its cells.
// ----------------------------------------------------------------------------
package fcwkt_pkg;

  localparam int KEY_W        = 24;
  localparam int HANDLE_W     = 16;
  localparam int CAP_W        = 5;
  localparam int OCC_W        = 5;
  localparam int DEPTH_DEF    = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_TAKE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_handle;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  // Broadcast controls seen by every cell in the row
  typedef struct packed {
    logic cmp;    // latch key compare
    logic take;   // take in progress: shift from the matching cell up
    logic shift;  // shift the whole row down one place
    logic clr;    // drop every entry
  } cell_ctl_t;

endpackage

FILE: rtl/core/fcwkt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwkt_cell
// One queue slot: key, handle and valid bit, a registered key compare, and
// the links to its neighbors for shifting, first-match search and read-out.
// ----------------------------------------------------------------------------
module fcwkt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  fcwkt_pkg::cell_ctl_t          ctl,
  input  logic [fcwkt_pkg::KEY_W-1:0]   cmp_key,
  input  logic [fcwkt_pkg::KEY_W-1:0]   ld_key,
  input  logic [fcwkt_pkg::HANDLE_W-1:0] ld_handle,
  input  logic                          load_sel,
  input  logic                          up_valid,
  input  logic [fcwkt_pkg::KEY_W-1:0]   up_key,
  input  logic [fcwkt_pkg::HANDLE_W-1:0] up_handle,
  input  logic                          found_in,
  input  logic [fcwkt_pkg::KEY_W-1:0]   acc_key_in,
  input  logic [fcwkt_pkg::HANDLE_W-1:0] acc_handle_in,
  output logic                          valid,
  output logic [fcwkt_pkg::KEY_W-1:0]   key,
  output logic [fcwkt_pkg::HANDLE_W-1:0] handle,
  output logic                          found_out,
  output logic [fcwkt_pkg::KEY_W-1:0]   acc_key_out,
  output logic [fcwkt_pkg::HANDLE_W-1:0] acc_handle_out
);

  logic match;
  logic sel;
  logic shift_en;

  assign found_out = found_in | match;
  // first matching cell in the row owns the read-out
  assign sel       = match & ~found_in;
  assign shift_en  = ctl.shift | (ctl.take & found_out);

  assign acc_key_out    = acc_key_in    | (sel ? key    : '0);
  assign acc_handle_out = acc_handle_in | (sel ? handle : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match <= valid && (key == cmp_key);
      end
      if (ctl.clr) begin
        valid <= 1'b0;
      end else if (load_sel) begin
        valid <= 1'b1;
      end else if (shift_en) begin
        valid <= up_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_sel) begin
      key    <= ld_key;
      handle <= ld_handle;
    end else if (shift_en) begin
      key    <= up_key;
      handle <= up_handle;
    end
  end

endmodule

FILE: rtl/core/fifo_cache_with_keyed_take_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_cache_with_keyed_take_core
// Age-ordered key/handle queue with FIFO eviction and take-by-key.
// ----------------------------------------------------------------------------
// The accept edge latches the command and lets every cell compare its key
// against the request in parallel; the edge that ends execution applies
// the put, take or clear across the row of cells and registers the result.
// busy is high for the one execute cycle only, so a new command can be
// accepted on the cycle the previous result is shown. The result beat is
// on rsp for exactly one cycle with done high and cannot be held off. A
// capacity write clears all entries and takes effect at once.
module fifo_cache_with_keyed_take_core #(
  parameter int DEPTH = fcwkt_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fcwkt_pkg::req_t               req,
  output logic                          done,
  output fcwkt_pkg::rsp_t               rsp,
  input  logic                          cfg_we,
  input  logic [fcwkt_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > fcwkt_pkg::CAP_W) ? CNT_W : fcwkt_pkg::CAP_W;

  fcwkt_pkg::state_t state, state_next;
  fcwkt_pkg::req_t   cmd;
  fcwkt_pkg::rsp_t   rsp_next;
  fcwkt_pkg::cell_ctl_t ctl;

  logic [fcwkt_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]            count, count_next;

  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_w;
  logic [CMP_W-1:0] load_pos;
  logic             exec;
  logic             full;
  logic             do_put;
  logic             do_load;

  logic [DEPTH:0]                     v_chain;
  logic [fcwkt_pkg::KEY_W-1:0]        k_chain   [DEPTH+1];
  logic [fcwkt_pkg::HANDLE_W-1:0]     h_chain   [DEPTH+1];
  logic [DEPTH:0]                     f_chain;
  logic [fcwkt_pkg::KEY_W-1:0]        ak_chain  [DEPTH+1];
  logic [fcwkt_pkg::HANDLE_W-1:0]     ah_chain  [DEPTH+1];
  logic [DEPTH-1:0]                   load_sel;
  logic [DEPTH-1:0]                   fill_mask;

  assign exec    = (state == fcwkt_pkg::ST_EXEC);
  assign busy    = exec;
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
  assign count_w = CMP_W'(count);
  assign full    = (count_w >= cap_eff);
  assign do_put  = exec && (cmd.op == fcwkt_pkg::OP_PUT) && (cap_eff != '0);
  assign do_load = do_put;
  // on a full put the row shifts down and the new entry lands in the top used slot
  assign load_pos = full ? (count_w - CMP_W'(1)) : count_w;

  always_comb begin
    ctl.cmp   = (state == fcwkt_pkg::ST_IDLE) && start;
    ctl.take  = exec && (cmd.op == fcwkt_pkg::OP_TAKE);
    ctl.shift = do_put && full;
    ctl.clr   = cfg_we || (exec && (cmd.op == fcwkt_pkg::OP_CLEAR));
  end

  // top of the row sees an empty neighbor; bottom of the search sees no match
  assign v_chain[DEPTH]  = 1'b0;
  assign k_chain[DEPTH]  = '0;
  assign h_chain[DEPTH]  = '0;
  assign f_chain[0]      = 1'b0;
  assign ak_chain[0]     = '0;
  assign ah_chain[0]     = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign load_sel[i]  = do_load && (CMP_W'(i) == load_pos);
    assign fill_mask[i] = (CMP_W'(i) < count_w);

    fcwkt_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .cmp_key        (req.key),
      .ld_key         (cmd.key),
      .ld_handle      (cmd.handle),
      .load_sel       (load_sel[i]),
      .up_valid       (v_chain[i+1]),
      .up_key         (k_chain[i+1]),
      .up_handle      (h_chain[i+1]),
      .found_in       (f_chain[i]),
      .acc_key_in     (ak_chain[i]),
      .acc_handle_in  (ah_chain[i]),
      .valid          (v_chain[i]),
      .key            (k_chain[i]),
      .handle         (h_chain[i]),
      .found_out      (f_chain[i+1]),
      .acc_key_out    (ak_chain[i+1]),
      .acc_handle_out (ah_chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rsp_next   = '0;
    unique case (state)
      fcwkt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = fcwkt_pkg::ST_EXEC;
        end
      end
      fcwkt_pkg::ST_EXEC: begin
        state_next = fcwkt_pkg::ST_IDLE;
        unique case (cmd.op)
          fcwkt_pkg::OP_PUT: begin
            if (cap_eff != '0) begin
              if (full) begin
                rsp_next.evicted    = 1'b1;
                rsp_next.out_key    = k_chain[0];
                rsp_next.out_handle = h_chain[0];
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
          end
          fcwkt_pkg::OP_TAKE: begin
            if (f_chain[DEPTH]) begin
              rsp_next.hit        = 1'b1;
              rsp_next.out_key    = ak_chain[DEPTH];
              rsp_next.out_handle = ah_chain[DEPTH];
              count_next          = count - CNT_W'(1);
            end
          end
          fcwkt_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          fcwkt_pkg::OP_NONE: begin
          end
          default: begin
          end
        endcase
        rsp_next.occupancy = fcwkt_pkg::OCC_W'(count_next);
      end
      default: begin
        state_next = fcwkt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fcwkt_pkg::ST_IDLE;
      capacity <= fcwkt_pkg::CAP_RESET;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        count    <= '0;
      end else begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      cmd <= req;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

  // valid entries always form an unbroken run from slot 0 of length count
  a_compact : assert property (@(posedge clk) disable iff (rst)
    v_chain[DEPTH-1:0] == fill_mask)
    else $error("valid bits not compacted to fill count");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count_w <= CMP_W'(DEPTH))
    else $error("fill count beyond depth");

  a_done_follows_exec : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == fcwkt_pkg::ST_EXEC)
    else $error("result beat without an executed command");

  a_hit_evict_excl : assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.hit && rsp.evicted))
    else $error("hit and evicted set in one beat");

  a_take_hit_shrinks : assert property (@(posedge clk) disable iff (rst)
    (exec && ctl.take && f_chain[DEPTH] && !cfg_we) |=> count == $past(count) - CNT_W'(1))
    else $error("take hit did not remove an entry");

endmodule

FILE: test/tb_fifo_cache_with_keyed_take_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_cache_with_keyed_take_core
// Self-checking bench for the keyed-take FIFO cache core. A short directed
// list covers field extremes, every command, duplicates, eviction, zero and
// oversized capacity. Phases of random put/take traffic on a small key pool
// follow, each at its own capacity and sender idle rate. A behavioral queue
// copy predicts each beat not typed in the list; all are compared by field.
// ----------------------------------------------------------------------------
module tb_fifo_cache_with_keyed_take_core;
  import fcwkt_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int PHASES     = 8;
  localparam int PHASE_CMDS = 150;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap_val;
    req_t             cmd;
    bit               typed;
    rsp_t             rsp;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  // expected result beats, oldest first
  rsp_t pending_rsp[$];
  int   mismatch_cnt;

  // shadow of the queue
  logic [KEY_W-1:0]    shadow_key[DEPTH];
  logic [HANDLE_W-1:0] shadow_handle[DEPTH];
  bit                  shadow_valid[DEPTH];
  int                  shadow_cap;

  // per-beat typed expectation, set alongside start
  bit   next_typed;
  rsp_t next_typed_rsp;

  int                idle_pct;
  logic [KEY_W-1:0]  key_pool[8];
  step_row_t         dir_rows[$];

  fifo_cache_with_keyed_take_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic void shadow_set_capacity(logic [CAP_W-1:0] v);
    shadow_cap = (v > DEPTH) ? DEPTH : int'(v);
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
  endfunction

  // slide slots above 'from' down one place up to 'last', free 'last'
  function automatic void shadow_close_gap(int from, int last);
    for (int i = from; i < last; i++) begin
      shadow_key[i]    = shadow_key[i+1];
      shadow_handle[i] = shadow_handle[i+1];
      shadow_valid[i]  = shadow_valid[i+1];
    end
    shadow_valid[last] = 1'b0;
  endfunction

  function automatic rsp_t cache_predict(req_t c);
    rsp_t r;
    bit   placed;
    int   occ;
    r      = '0;
    placed = 1'b0;
    occ    = 0;
    case (c.op)
      OP_PUT: begin
        if (shadow_cap != 0) begin
          for (int i = 0; i < shadow_cap; i++) begin
            if (!placed && !shadow_valid[i]) begin
              shadow_key[i]    = c.key;
              shadow_handle[i] = c.handle;
              shadow_valid[i]  = 1'b1;
              placed           = 1'b1;
            end
          end
          if (!placed) begin
            // full: evict the head and append at the top
            r.evicted    = 1'b1;
            r.out_key    = shadow_key[0];
            r.out_handle = shadow_handle[0];
            shadow_close_gap(0, shadow_cap - 1);
            shadow_key[shadow_cap-1]    = c.key;
            shadow_handle[shadow_cap-1] = c.handle;
            shadow_valid[shadow_cap-1]  = 1'b1;
          end
        end
      end
      OP_TAKE: begin
        for (int i = 0; i < shadow_cap; i++) begin
          if (!placed) begin
            if (!shadow_valid[i]) begin
              placed = 1'b1;
            end else if (shadow_key[i] == c.key) begin
              r.hit        = 1'b1;
              r.out_key    = shadow_key[i];
              r.out_handle = shadow_handle[i];
              shadow_close_gap(i, shadow_cap - 1);
              placed = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    foreach (shadow_valid[i]) if (shadow_valid[i]) occ++;
    r.occupancy = occ[OCC_W-1:0];
    return r;
  endfunction

  // check result beats, then log configuration and accepted commands
  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    if (!rst) begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch("result beat with nothing pending", 32'(rsp.occupancy), 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.hit !== want.hit) flag_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
          if (rsp.evicted !== want.evicted) begin
            flag_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
          end
          if (rsp.out_key !== want.out_key) begin
            flag_mismatch("out_key", 32'(rsp.out_key), 32'(want.out_key));
          end
          if (rsp.out_handle !== want.out_handle) begin
            flag_mismatch("out_handle", 32'(rsp.out_handle), 32'(want.out_handle));
          end
          if (rsp.occupancy !== want.occupancy) begin
            flag_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
          end
        end
      end
      if (cfg_we) shadow_set_capacity(cfg_wdata);
      if (start && !busy) begin
        pred = cache_predict(req);
        pending_rsp.push_back(next_typed ? next_typed_rsp : pred);
      end
    end
  end

  // enter just after an accept edge (or at the start); return on the accept edge
  task automatic drive_cmd(req_t c, bit typed, rsp_t t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    req            = c;
    next_typed     = typed;
    next_typed_rsp = t;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // hold off until every pending beat has come back, then let the core settle
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic req_t mk_cmd(op_t op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    req_t c;
    c.op     = op;
    c.key    = k;
    c.handle = h;
    return c;
  endfunction

  function automatic void add_cmd(op_t op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    step_row_t row;
    row        = '{default: '0};
    row.cmd    = mk_cmd(op, k, h);
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(op_t op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h,
                                    logic ht, logic ev, logic [KEY_W-1:0] ok,
                                    logic [HANDLE_W-1:0] oh, logic [OCC_W-1:0] occ);
    step_row_t row;
    row       = '{default: '0};
    row.cmd   = mk_cmd(op, k, h);
    row.typed = 1'b1;
    row.rsp   = '{hit: ht, evicted: ev, out_key: ok, out_handle: oh, occupancy: occ};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cap(logic [CAP_W-1:0] v);
    step_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cap_val = v;
    dir_rows.push_back(row);
  endfunction

  function automatic req_t random_cmd();
    req_t c;
    int   r;
    r        = $urandom_range(99);
    c.handle = HANDLE_W'($urandom);
    c.key    = ($urandom_range(99) < 70) ? key_pool[$urandom_range(7)] : KEY_W'($urandom);
    if (r < 50)      c.op = OP_PUT;
    else if (r < 95) c.op = OP_TAKE;
    else if (r < 97) c.op = OP_CLEAR;
    else             c.op = OP_NONE;
    return c;
  endfunction

  initial begin
    logic [CAP_W-1:0] caps[PHASES];
    int               pcts[4];
    rsp_t             no_rsp;

    start        = 1'b0;
    req          = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst          = 1'b1;
    next_typed   = 1'b0;
    next_typed_rsp = '0;
    mismatch_cnt = 0;
    idle_pct     = 0;
    no_rsp       = '0;
    shadow_set_capacity(CAP_RESET);
    foreach (shadow_key[i]) begin
      shadow_key[i]    = '0;
      shadow_handle[i] = '0;
    end

    // directed list
    add_typed(OP_TAKE, 24'h000000, 16'h0000, 0, 0, 24'h0, 16'h0, 5'd0);
    add_typed(OP_NONE, 24'hFFFFFF, 16'hFFFF, 0, 0, 24'h0, 16'h0, 5'd0);
    add_typed(OP_PUT, 24'hFFFFFF, 16'hFFFF, 0, 0, 24'h0, 16'h0, 5'd1);
    add_typed(OP_PUT, 24'h000000, 16'h0000, 0, 0, 24'h0, 16'h0, 5'd2);
    add_typed(OP_PUT, 24'h123456, 16'hA5A5, 0, 0, 24'h0, 16'h0, 5'd3);
    add_typed(OP_PUT, 24'h000000, 16'h5A5A, 0, 0, 24'h0, 16'h0, 5'd4);
    add_typed(OP_TAKE, 24'h000000, 16'hFFFF, 1, 0, 24'h000000, 16'h0000, 5'd3);
    add_typed(OP_TAKE, 24'h000000, 16'h0000, 1, 0, 24'h000000, 16'h5A5A, 5'd2);
    add_typed(OP_TAKE, 24'hFFFFFF, 16'h0000, 1, 0, 24'hFFFFFF, 16'hFFFF, 5'd1);
    add_typed(OP_NONE, 24'h123456, 16'h1234, 0, 0, 24'h0, 16'h0, 5'd1);
    add_typed(OP_CLEAR, 24'h123456, 16'h1234, 0, 0, 24'h0, 16'h0, 5'd0);
    add_cap(5'd2);
    add_cmd(OP_PUT, 24'h000001, 16'h0011);
    add_cmd(OP_PUT, 24'h000002, 16'h0022);
    add_typed(OP_PUT, 24'h000003, 16'h0033, 0, 1, 24'h000001, 16'h0011, 5'd2);
    add_cmd(OP_TAKE, 24'h000002, 16'h0000);
    add_cap(5'd0);
    add_typed(OP_PUT, 24'h000005, 16'hBEEF, 0, 0, 24'h0, 16'h0, 5'd0);
    add_typed(OP_TAKE, 24'h000005, 16'h0000, 0, 0, 24'h0, 16'h0, 5'd0);
    add_cap(5'd31);
    add_cmd(OP_PUT, 24'hAAAAAA, 16'h5555);
    add_cmd(OP_TAKE, 24'h555555, 16'hAAAA);
    add_cap(5'd1);
    add_typed(OP_PUT, 24'h000007, 16'h0077, 0, 0, 24'h0, 16'h0, 5'd1);
    add_typed(OP_PUT, 24'h000008, 16'h0088, 0, 1, 24'h000007, 16'h0077, 5'd1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].cap_val);
      end else begin
        drive_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rsp);
      end
    end

    // random phases: capacity and sender idle rate change per phase
    caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, CAP_W'($urandom_range(2, 15)), 5'd17, 5'd16};
    pcts = '{0, 66, 26, 0};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(caps[ph]);
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (n == PHASE_CMDS / 2) wait_drained();
        drive_cmd(random_cmd(), 1'b0, no_rsp);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
